### rtl/alias_table_sampler_top_macros.svh
// Assertion macros for the alias table sampler.
// Used by alias_table_sampler_top; relies on i_clk and i_rst_n in scope.
`ifndef ALIAS_TABLE_SAMPLER_TOP_MACROS_SVH
`define ALIAS_TABLE_SAMPLER_TOP_MACROS_SVH

// condition must hold at every edge out of reset
`define ATS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ats_pkg.sv
// Types and fixed constants of the alias table sampler.
// No dependencies.
package ats_pkg;

    localparam int PROB_W = 17;
    localparam int THR_W  = 25;
    localparam int RIN_W  = 32;
    localparam int OIDX_W = 8;

    typedef enum logic [1:0] {
        STAT_SAMPLE     = 2'd0,
        STAT_BUILT      = 2'd1,
        STAT_BUILT_DROP = 2'd2,
        STAT_REJECT     = 2'd3
    } t_status;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_B_RD  = 13'b0000000000010,
        ST_B_MUL = 13'b0000000000100,
        ST_B_WR  = 13'b0000000001000,
        ST_P_POP = 13'b0000000010000,
        ST_P_RDT = 13'b0000000100000,
        ST_P_UPD = 13'b0000001000000,
        ST_L_WR  = 13'b0000010000000,
        ST_S_MUL = 13'b0000100000000,
        ST_S_RD  = 13'b0001000000000,
        ST_S_CMP = 13'b0010000000000,
        ST_S_PRB = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } t_state;

endpackage

### rtl/alias_table_sampler_top.sv
// Alias table sampler: load, table build and sampling under one sequencer.
// Depends on ats_pkg and alias_table_sampler_top_macros.svh.
//
// channel | dir | tdata                           | tuser       | tlast
// s_*     | in  | weight[16:0], rand_req[48:17]   | mode        | last
// m_*     | out | index[7:0], chosen_prob[24:8]   | status[1:0] | -
//
// Load: a weight is written when accepted, if the table has room. The last load adds the build:
// per entry a threshold pass (memory read, shared multiplier, write), then pairing
// steps (pop, table read, update), leftover steps (pop, write), then the result post.
// Sample: multiply, table read, compare and prob read, result latch, output;
// a rejected sample goes straight to the output step.
// Sync active-low reset clears control state; memories are not cleared.
// A result waiting on m_tready holds the sequencer in its output step.
module alias_table_sampler_top
    import ats_pkg::*;
#(
    parameter int ENTRIES   = 256,
    parameter int FRAC_BITS = 16,
    parameter int RAND_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // weight[16:0], rand_req[48:17], zero fill
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // index[7:0], chosen_prob[24:8], zero fill
    output logic [1:0]  m_tuser    // status
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int MW  = (RAND_BITS > PROB_W) ? RAND_BITS : PROB_W;
    localparam int RL  = (RAND_BITS < RIN_W) ? RAND_BITS : RIN_W;
    localparam int PW0 = CW + MW;
    localparam int PW  = (PW0 > THR_W + 1) ? PW0 : THR_W + 1;
    localparam int AW  = (RAND_BITS > FRAC_BITS) ? RAND_BITS : FRAC_BITS;
    localparam logic [THR_W-1:0] ONE_FX  = THR_W'(1) << FRAC_BITS;
    localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

    // memories
    logic [PROB_W-1:0] prob_mem  [ENTRIES];
    logic [THR_W-1:0]  thr_mem   [ENTRIES];
    logic [IW-1:0]     alias_mem [ENTRIES];
    logic [IW-1:0]     over_mem  [ENTRIES];
    logic [IW-1:0]     under_mem [ENTRIES];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_dropped, n_dropped;
    logic              r_ready, n_ready;
    logic [CW-1:0]     r_ot, n_ot, r_ut, n_ut;
    logic [CW-1:0]     r_k, n_k;
    logic              r_lo_over, n_lo_over;
    logic [RAND_BITS-1:0] r_rand;
    logic [PW0-1:0]    r_prod;
    logic [IW-1:0]     r_si, r_pi, r_pj, r_pick;
    logic [RAND_BITS-1:0] r_y;
    logic [1:0]        r_res_stat;
    logic [OIDX_W-1:0] r_res_idx;
    logic [PROB_W-1:0] r_res_prob;
    logic              r_mvalid;
    logic [1:0]        r_mstat;
    logic [OIDX_W-1:0] r_midx;
    logic [PROB_W-1:0] r_mprob;

    logic [PROB_W-1:0] prob_rd;
    logic [THR_W-1:0]  thr_rd_a, thr_rd_b;
    logic [IW-1:0]     alias_rd, over_rd, under_rd;

    logic              in_acc;
    logic [PROB_W-1:0] in_weight;
    logic [RAND_BITS-1:0] in_rand;
    logic [CW-1:0]     eff_cnt;
    logic              prob_we;
    logic [IW-1:0]     prob_ra;
    logic              thr_we;
    logic [IW-1:0]     thr_wa;
    logic [THR_W-1:0]  thr_wd;
    logic [IW-1:0]     thr_ra;
    logic              alias_we;
    logic [IW-1:0]     alias_wa, alias_wd;
    logic              over_we, under_we;
    logic [IW-1:0]     push_d;
    logic [MW-1:0]     mul_op;
    logic [PW-1:0]     prod_ext;
    logic [THR_W-1:0]  sat_thr;
    logic [THR_W:0]    pair_sum;
    logic [THR_W-1:0]  pair_u;
    logic [CW-1:0]     si_full, si_clamp;
    logic [AW-1:0]     y_al, u_al;
    logic              below;
    logic [IW-1:0]     pick;
    logic [IW+OIDX_W-1:0] pick_ext;
    logic [CW+OIDX_W-1:0] cnt_ext;
    logic [CW:0]       stk_sum;
    logic              ld_last;
    logic              in_build_wr;

    assign in_acc    = s_tvalid && s_tready;
    assign in_weight = s_tdata[PROB_W-1:0];
    assign in_rand   = RAND_BITS'(s_tdata[PROB_W +: RL]);
    assign s_tready  = (r_state == ST_IDLE);
    assign eff_cnt   = r_ready ? '0 : r_count;

    // shared multiplier operand: random fraction on samples, weight on build
    assign mul_op   = (r_state == ST_S_MUL) ? MW'(r_rand) : MW'(prob_rd);
    assign prod_ext = PW'(r_prod);
    assign sat_thr  = (prod_ext > PW'(THR_MAX)) ? THR_MAX : prod_ext[THR_W-1:0];
    assign pair_sum = {1'b0, thr_rd_a} + {1'b0, thr_rd_b} - {1'b0, ONE_FX};
    assign pair_u   = pair_sum[THR_W-1:0];

    assign si_full  = r_prod[RAND_BITS +: CW];
    assign si_clamp = (si_full >= r_count) ? r_count - CW'(1) : si_full;

    assign y_al  = AW'(r_y) << (AW - RAND_BITS);
    assign u_al  = AW'(thr_rd_a[FRAC_BITS-1:0]) << (AW - FRAC_BITS);
    assign below = (thr_rd_a >= ONE_FX) || (y_al < u_al);
    assign pick  = below ? r_si : alias_rd;
    assign pick_ext = {{OIDX_W{1'b0}}, r_pick};
    assign cnt_ext  = {{OIDX_W{1'b0}}, r_count - CW'(1)};
    assign stk_sum  = {1'b0, r_ot} + {1'b0, r_ut};

    assign ld_last     = in_acc && !s_tuser && s_tlast;
    assign in_build_wr = r_state inside {ST_B_WR, ST_P_UPD, ST_L_WR};

    // memory port control
    always_comb begin
        prob_we  = in_acc && !s_tuser && (eff_cnt < CW'(ENTRIES));
        prob_ra  = (r_state == ST_B_RD) ? r_k[IW-1:0] : pick;
        thr_ra   = (r_state == ST_S_RD) ? si_clamp[IW-1:0] : over_rd;
        thr_we   = 1'b0;
        thr_wa   = r_k[IW-1:0];
        thr_wd   = sat_thr;
        alias_we = 1'b0;
        alias_wa = r_k[IW-1:0];
        alias_wd = r_k[IW-1:0];
        over_we  = 1'b0;
        under_we = 1'b0;
        push_d   = r_k[IW-1:0];
        case (r_state)
            ST_B_WR: begin
                thr_we   = 1'b1;
                alias_we = 1'b1;
                over_we  = sat_thr > ONE_FX;
                under_we = sat_thr < ONE_FX;
            end
            ST_P_UPD: begin
                thr_we   = 1'b1;
                thr_wa   = r_pi;
                thr_wd   = pair_u;
                alias_we = 1'b1;
                alias_wa = r_pj;
                alias_wd = r_pi;
                push_d   = r_pi;
                over_we  = pair_u > ONE_FX;
                under_we = pair_u < ONE_FX;
            end
            ST_L_WR: begin
                thr_we = 1'b1;
                thr_wa = r_lo_over ? over_rd : under_rd;
                thr_wd = ONE_FX;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (prob_we) prob_mem[eff_cnt[IW-1:0]] <= in_weight;
        if (r_state == ST_B_RD || r_state == ST_S_CMP) prob_rd <= prob_mem[prob_ra];
    end

    always_ff @(posedge i_clk) begin
        if (thr_we) thr_mem[thr_wa] <= thr_wd;
        if (r_state == ST_P_RDT || r_state == ST_S_RD) begin
            thr_rd_a <= thr_mem[thr_ra];
            thr_rd_b <= thr_mem[under_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (alias_we) alias_mem[alias_wa] <= alias_wd;
        if (r_state == ST_S_RD) alias_rd <= alias_mem[si_clamp[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (over_we) over_mem[r_ot[IW-1:0]] <= push_d;
        if (r_state == ST_P_POP && r_ot != '0) over_rd <= over_mem[n_ot[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (under_we) under_mem[r_ut[IW-1:0]] <= push_d;
        if (r_state == ST_P_POP && r_ut != '0 && (r_ot == '0 || !n_lo_over))
            under_rd <= under_mem[n_ut[IW-1:0]];
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_ready   = r_ready;
        n_ot      = r_ot;
        n_ut      = r_ut;
        n_k       = r_k;
        n_lo_over = r_lo_over;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && !s_tuser) begin
                    n_ready = 1'b0;
                    if (r_ready) n_dropped = 1'b0;
                    if (eff_cnt < CW'(ENTRIES)) n_count = eff_cnt + CW'(1);
                    else begin
                        n_count   = eff_cnt;
                        n_dropped = 1'b1;
                    end
                    if (s_tlast) begin
                        n_state = ST_B_RD;
                        n_k     = '0;
                        n_ot    = '0;
                        n_ut    = '0;
                    end
                end else if (in_acc) begin
                    if (!r_ready || r_count == '0) n_state = ST_OUT;
                    else n_state = ST_S_MUL;
                end
            end
            ST_B_RD:  n_state = ST_B_MUL;
            ST_B_MUL: n_state = ST_B_WR;
            ST_B_WR: begin
                if (sat_thr > ONE_FX) n_ot = r_ot + CW'(1);
                if (sat_thr < ONE_FX) n_ut = r_ut + CW'(1);
                n_k = r_k + CW'(1);
                n_state = (n_k == r_count) ? ST_P_POP : ST_B_RD;
            end
            ST_P_POP: begin
                if (r_ot != '0 && r_ut != '0) begin
                    n_ot = r_ot - CW'(1);
                    n_ut = r_ut - CW'(1);
                    n_lo_over = 1'b0;
                    n_state = ST_P_RDT;
                end else if (r_ot != '0) begin
                    n_ot = r_ot - CW'(1);
                    n_lo_over = 1'b1;
                    n_state = ST_L_WR;
                end else if (r_ut != '0) begin
                    n_ut = r_ut - CW'(1);
                    n_lo_over = 1'b0;
                    n_state = ST_L_WR;
                end else begin
                    n_ready = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_P_RDT: n_state = ST_P_UPD;
            ST_P_UPD: begin
                if (pair_u > ONE_FX) n_ot = r_ot + CW'(1);
                if (pair_u < ONE_FX) n_ut = r_ut + CW'(1);
                n_state = ST_P_POP;
            end
            ST_L_WR:  n_state = ST_P_POP;
            ST_S_MUL: n_state = ST_S_RD;
            ST_S_RD:  n_state = ST_S_CMP;
            ST_S_CMP: n_state = ST_S_PRB;
            ST_S_PRB: n_state = ST_OUT;
            ST_OUT: if (!r_mvalid || m_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_ready   <= 1'b0;
            r_ot      <= '0;
            r_ut      <= '0;
            r_k       <= '0;
            r_lo_over <= 1'b0;
            r_mvalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_ready   <= n_ready;
            r_ot      <= n_ot;
            r_ut      <= n_ut;
            r_k       <= n_k;
            r_lo_over <= n_lo_over;
            if (r_state == ST_OUT && (!r_mvalid || m_tready)) r_mvalid <= 1'b1;
            else if (m_tready) r_mvalid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) r_rand <= in_rand;
        if (r_state == ST_B_MUL || r_state == ST_S_MUL)
            r_prod <= PW0'(r_count) * PW0'(mul_op);
        if (r_state == ST_P_RDT) begin
            r_pi <= over_rd;
            r_pj <= under_rd;
        end
        if (r_state == ST_S_RD) begin
            r_si <= si_clamp[IW-1:0];
            r_y  <= r_prod[RAND_BITS-1:0];
        end
        if (r_state == ST_S_CMP) r_pick <= pick;

        if (in_acc && s_tuser) begin
            r_res_stat <= STAT_REJECT;
            r_res_idx  <= '0;
            r_res_prob <= '0;
        end else if (r_state == ST_P_POP && n_state == ST_OUT) begin
            r_res_stat <= r_dropped ? STAT_BUILT_DROP : STAT_BUILT;
            r_res_idx  <= cnt_ext[OIDX_W-1:0];
            r_res_prob <= '0;
        end else if (r_state == ST_S_PRB) begin
            r_res_stat <= STAT_SAMPLE;
            r_res_idx  <= pick_ext[OIDX_W-1:0];
            r_res_prob <= prob_rd;
        end

        if (r_state == ST_OUT && (!r_mvalid || m_tready)) begin
            r_mstat <= r_res_stat;
            r_midx  <= r_res_idx;
            r_mprob <= r_res_prob;
        end
    end

    assign m_tvalid = r_mvalid;
    assign m_tuser  = r_mstat;
    assign m_tdata  = {7'b0, r_mprob, r_midx};

    `include "alias_table_sampler_top_macros.svh"

    `ATS_ASSERT_ALWAYS(a_stack_bound, stk_sum <= {1'b0, r_count}, "stacks exceed entry count")
    `ATS_ASSERT_NEXT(a_last_builds, ld_last, r_state == ST_B_RD, "last load did not start build")
    `ATS_ASSERT_ALWAYS(a_build_not_ready, !in_build_wr || !r_ready, "table ready during build")

endmodule

### tb/alias_checker.sv
// Checker for the alias table sampler: watches both stream channels, predicts results
// from accepted requests and compares them field by field. Depends on ats_pkg.
module alias_checker
    import ats_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // weight[16:0], rand_req[48:17], zero fill
    input  logic        s_tuser,   // mode
    input  logic        s_tlast,   // last
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // index[7:0], chosen_prob[24:8], zero fill
    input  logic [1:0]  m_tuser,   // status
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = 256;
    localparam logic [24:0] ONE_Q = 25'd65536;
    localparam logic [24:0] THR_TOP = 25'h1FFFFFF;

    typedef struct packed {
        t_status     status;
        logic [7:0]  index;
        logic [16:0] prob;
    } t_draw;

    t_draw       expected_q[$];
    logic [16:0] weights[NENT];
    logic [24:0] thresh[NENT];
    logic [7:0]  partner[NENT];
    int          n_loaded;
    bit          overflowed;
    bit          ready;

    assign o_pending = expected_q.size();

    function automatic void build_alias_table();
        int          heavy[NENT];
        int          light[NENT];
        int          n_heavy;
        int          n_light;
        int          i;
        int          j;
        logic [47:0] prod;
        n_heavy = 0;
        n_light = 0;
        for (int k = 0; k < n_loaded; k++) begin
            prod = 48'(n_loaded) * 48'(weights[k]);
            thresh[k] = (prod > 48'(THR_TOP)) ? THR_TOP : prod[24:0];
            partner[k] = 8'(k);
            if (thresh[k] < ONE_Q) begin
                light[n_light] = k;
                n_light++;
            end else if (thresh[k] > ONE_Q) begin
                heavy[n_heavy] = k;
                n_heavy++;
            end
        end
        while (n_heavy > 0 && n_light > 0) begin
            n_heavy--;
            n_light--;
            i = heavy[n_heavy];
            j = light[n_light];
            thresh[i] = thresh[i] + thresh[j] - ONE_Q;
            partner[j] = 8'(i);
            if (thresh[i] < ONE_Q) begin
                light[n_light] = i;
                n_light++;
            end else if (thresh[i] > ONE_Q) begin
                heavy[n_heavy] = i;
                n_heavy++;
            end else begin
                partner[i] = 8'(i);
            end
        end
        while (n_heavy > 0) begin
            n_heavy--;
            thresh[heavy[n_heavy]] = ONE_Q;
            partner[heavy[n_heavy]] = 8'(heavy[n_heavy]);
        end
        while (n_light > 0) begin
            n_light--;
            thresh[light[n_light]] = ONE_Q;
            partner[light[n_light]] = 8'(light[n_light]);
        end
        ready = 1;
    endfunction

    function automatic void predict_request(logic mode, logic [16:0] w, logic lst,
                                            logic [31:0] r);
        t_draw       d;
        logic [63:0] nx;
        int          i;
        int          pick;
        if (!mode) begin
            if (ready) begin
                n_loaded = 0;
                overflowed = 0;
                ready = 0;
            end
            if (n_loaded < NENT) begin
                weights[n_loaded] = w;
                n_loaded++;
            end else begin
                overflowed = 1;
            end
            if (!lst) return;
            build_alias_table();
            d.status = overflowed ? STAT_BUILT_DROP : STAT_BUILT;
            d.index = 8'(n_loaded - 1);
            d.prob = '0;
        end else if (!ready || n_loaded == 0) begin
            d.status = STAT_REJECT;
            d.index = '0;
            d.prob = '0;
        end else begin
            nx = 64'(n_loaded) * 64'(r);
            i = int'(nx[63:32]);
            if (i >= n_loaded) i = n_loaded - 1;
            if (thresh[i] >= ONE_Q || nx[31:0] < {thresh[i][15:0], 16'd0}) pick = i;
            else pick = partner[i];
            d.status = STAT_SAMPLE;
            d.index = 8'(pick);
            d.prob = weights[pick];
        end
        expected_q = {expected_q, d};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_draw d;
        if (!i_rst_n) begin
            o_fail_count = 0;
            n_loaded = 0;
            overflowed = 0;
            ready = 0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result status", m_tuser, -1);
                end else begin
                    d = expected_q.pop_front();
                    if (m_tuser != d.status) report_mismatch("status", m_tuser, d.status);
                    if (m_tdata[7:0] != d.index) report_mismatch("index", m_tdata[7:0], d.index);
                    if (m_tdata[24:8] != d.prob)
                        report_mismatch("chosen_prob", m_tdata[24:8], d.prob);
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[16:0], s_tlast, s_tdata[48:17]);
        end
    end

    final if (expected_q.size() > 0) $display("%0d results never arrived", expected_q.size());
endmodule

### tb/tb_top.sv
// Top of the alias table sampler testbench: clock, reset, request stimulus, verdict.
// Depends on ats_pkg, alias_table_sampler_top and alias_checker.
module tb_top;
    import ats_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    bit          stall_free;
    int          out_wait;
    int          draw_w;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    alias_table_sampler_top dut (.*);

    alias_checker checker_i (
        .i_clk, .i_rst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // valid stays up between back-to-back requests; it drops only for a gap
    task automatic send_request(logic mode, logic [16:0] w, logic lst, logic [31:0] r);
        int gap;
        gap = stall_free ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tlast  <= lst;
        s_tdata  <= {7'd0, r, w};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic load_table(int n, int style);
        logic [16:0] w;
        for (int k = 0; k < n; k++) begin
            case (style)
                0: w = 17'(65536 / n);
                1: w = 17'($urandom_range(0, 65536));
                2: w = 17'($urandom);
                default: w = (k == 0) ? 17'd65536 : 17'd0;
            endcase
            send_request(1'b0, w, k == n - 1, $urandom);
        end
    endtask

    task automatic draw_samples(int cnt);
        logic [31:0] r;
        for (int k = 0; k < cnt; k++) begin
            case ($urandom_range(0, 5))
                0: r = 32'hFFFFFFFF;
                1: r = 32'd0;
                default: r = $urandom;
            endcase
            send_request(1'b1, 17'($urandom), 1'($urandom), r);
        end
    endtask

    // ready side: after each result a new wait is drawn at random; none when stall_free is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 0;
            out_wait <= 0;
        end else if (m_tvalid && m_tready) begin
            draw_w = stall_free ? 0 : $urandom_range(0, 6);
            out_wait <= draw_w;
            m_tready <= (draw_w == 0);
        end else if (m_tvalid && !m_tready) begin
            if (out_wait <= 1) m_tready <= 1;
            else out_wait <= out_wait - 1;
        end
    end

    initial begin
        int n;
        stall_free = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: sample before any build, tiny tables, extremes
        send_request(1'b1, 17'h1FFFF, 1'b1, 32'hFFFFFFFF);
        send_request(1'b0, 17'd65536, 1'b1, 32'd0);
        send_request(1'b1, 17'd0, 1'b0, 32'd0);
        send_request(1'b1, 17'd0, 1'b0, 32'hFFFFFFFF);
        load_table(2, 3);
        draw_samples(3);
        send_request(1'b0, 17'h1FFFF, 1'b0, 32'hFFFFFFFF);
        send_request(1'b0, 17'd0, 1'b1, 32'd0);
        draw_samples(3);
        send_request(1'b0, 17'd1, 1'b0, 32'd0);
        send_request(1'b1, 17'd0, 1'b0, 32'h80000000);
        send_request(1'b0, 17'd3, 1'b1, 32'd0);
        draw_samples(2);
        // random phases
        for (int ph = 0; ph < 12; ph++) begin
            stall_free = (ph % 4 == 3);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(2, 12);
            load_table(n, $urandom_range(0, 3));
            draw_samples($urandom_range(20, 45));
        end
        // full table plus dropped loads past capacity
        stall_free = 1;
        load_table(259, 1);
        stall_free = 0;
        draw_samples(40);
        s_tvalid <= 0;
        while (pending > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) $display("PASSED: all results match");
        else $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
